// File: design/mopl_pkg.sv
// ============================================================================
// mopl_pkg
// Shared widths, the pole coefficient table and the functions that build it.
// ============================================================================
`default_nettype none

package mopl_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int TABLE_ENTRIES = 128;
    localparam int INDEX_W       = $clog2(TABLE_ENTRIES);
    localparam int OCTAVES       = (TABLE_ENTRIES + 11) / 12;

    // Base angular step in Q48 for the lowest note.
    localparam logic [63:0] W0_Q48 = 64'd301237215321;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef logic [TABLE_ENTRIES-1:0][SAMPLE_W-1:0] pole_table_t;

    // Semitone ratios 2^(n/12) in Q24.
    function automatic logic [63:0] semi_q24(input int unsigned semi);
        logic [63:0] r;
        case (semi)
            0:       r = 64'd16777216;
            1:       r = 64'd17774841;
            2:       r = 64'd18831788;
            3:       r = 64'd19951585;
            4:       r = 64'd21137968;
            5:       r = 64'd22394897;
            6:       r = 64'd23726566;
            7:       r = 64'd25137421;
            8:       r = 64'd26632170;
            9:       r = 64'd28215802;
            10:      r = 64'd29893600;
            11:      r = 64'd31671166;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    // exp(-w) in Q0.32: a short Taylor series on w/16, then squared four times.
    function automatic logic [SAMPLE_W-1:0] pole_for_note(input int unsigned oct,
                                                          input int unsigned semi);
        logic [63:0] w;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] p;
        w = (W0_Q48 * semi_q24(semi)) >> (40 - oct);
        t = w >> 4;
        e = ONE_Q32 - t;
        p = (t * t) >> 32;  e = e + p / 64'd2;
        p = (p * t) >> 32;  e = e - p / 64'd6;
        p = (p * t) >> 32;  e = e + p / 64'd24;
        p = (p * t) >> 32;  e = e - p / 64'd120;
        p = (p * t) >> 32;  e = e + p / 64'd720;
        if (e > 64'h0000_0000_FFFF_FFFF)
        begin
            e = 64'h0000_0000_FFFF_FFFF;
        end
        for (int k = 0; k < 4; k++)
        begin
            e = (e * e) >> 32;
        end
        return e[SAMPLE_W-1:0];
    endfunction

    function automatic pole_table_t build_pole_table();
        pole_table_t tbl;
        int unsigned n;
        tbl = '0;
        for (int unsigned oct = 0; oct < OCTAVES; oct++)
        begin
            for (int unsigned semi = 0; semi < 12; semi++)
            begin
                n = oct * 12 + semi;
                if (n < TABLE_ENTRIES)
                begin
                    tbl[n] = pole_for_note(oct, semi);
                end
            end
        end
        return tbl;
    endfunction

    localparam pole_table_t POLE_TABLE = build_pole_table();

endpackage

`default_nettype wire

// File: design/mopl_in_if.sv
// ============================================================================
// mopl_in_if
// Input channel: one audio sample with its cutoff and modulation per beat.
// ============================================================================
`default_nettype none

interface mopl_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [mopl_pkg::SAMPLE_W-1:0]   audio_sample;
    logic signed [mopl_pkg::SAMPLE_W-1:0]   cutoff_level;
    logic signed [mopl_pkg::SAMPLE_W-1:0]   mod_source;
    logic signed [mopl_pkg::SAMPLE_W-1:0]   mod_amount;

    modport source (
        output valid,
        output audio_sample,
        output cutoff_level,
        output mod_source,
        output mod_amount,
        input  ready
    );

    modport sink (
        input  valid,
        input  audio_sample,
        input  cutoff_level,
        input  mod_source,
        input  mod_amount,
        output ready
    );

endinterface

`default_nettype wire

// File: design/mopl_out_if.sv
// ============================================================================
// mopl_out_if
// Output channel: one filtered sample per beat.
// ============================================================================
`default_nettype none

interface mopl_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [mopl_pkg::SAMPLE_W-1:0]   filtered_sample;

    modport source (
        output valid,
        output filtered_sample,
        input  ready
    );

    modport sink (
        input  valid,
        input  filtered_sample,
        output ready
    );

endinterface

`default_nettype wire

// File: design/modulated_one_pole_lowpass_core.sv
// ============================================================================
// modulated_one_pole_lowpass_core
// One-pole lowpass on signed 32-bit audio with a modulated cutoff. Each input
// beat carries a sample, a base cutoff, a modulation source and a depth; the
// cutoff is offset by (depth * source) >> 32, clamped, and its top byte picks
// one of 128 Q0.32 pole coefficients b from a constant table. The filter runs
// y = x + b * (y_prev - x) / 2^32 in an offset-unsigned domain and returns
// y - (2^31 - 1), saturated at the positive limit. A single 33x33 signed
// multiplier is used twice per sample (modulation product, then the pole
// product) under a five-state sequencer, and no new sample is accepted
// until the sequencer is back in idle. The result sits in an output
// register, so the next sample is taken while the previous beat waits.
// ============================================================================
`default_nettype none

module modulated_one_pole_lowpass_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mopl_in_if.sink     samples,
    mopl_out_if.source  results
);

    localparam int W = mopl_pkg::SAMPLE_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MOD  = 5'b00010,
        ST_LOOK = 5'b00100,
        ST_FILT = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [W-1:0]                   x_reg;
    logic [W-1:0]                   cutoff_reg;
    logic [W-1:0]                   source_reg;
    logic [W-1:0]                   amount_reg;
    logic [2*W+1:0]                 prod_reg;
    logic [W-1:0]                   b_reg;
    logic [W:0]                     d_reg;
    logic [W-1:0]                   y_prev_reg;
    logic                           out_valid_reg;
    logic [W-1:0]                   out_data_reg;

    logic signed [W:0]              mul_a;
    logic signed [W:0]              mul_b;
    logic signed [2*W+1:0]          mul_p;
    logic [W:0]                     x_wide;
    logic [W-1:0]                   x_in;
    logic [W:0]                     cut_sum;
    logic [mopl_pkg::INDEX_W-1:0]   idx;
    logic [W:0]                     d_next;
    logic [2*W+1:0]                 num;
    logic [W-1:0]                   y_sat;
    logic [W-1:0]                   res;
    logic                           accept;
    logic                           out_free;

    assign accept         = samples.valid && samples.ready;
    assign out_free       = !out_valid_reg || results.ready;
    assign samples.ready  = (state_reg == ST_IDLE);

    // The shared multiplier: modulation product first, pole product later.
    always_comb
    begin
        if (state_reg == ST_FILT)
        begin
            mul_a = signed'({1'b0, b_reg});
            mul_b = signed'(d_reg);
        end
        else
        begin
            mul_a = signed'({amount_reg[W-1], amount_reg});
            mul_b = signed'({source_reg[W-1], source_reg});
        end
    end

    assign mul_p = mul_a * mul_b;

    // Offset the sample by 2^31 - 1; the most negative sample clamps to zero.
    assign x_wide = {1'b0, ~samples.audio_sample[W-1], samples.audio_sample[W-2:0]}
                    - {{W{1'b0}}, 1'b1};
    assign x_in   = x_wide[W] ? '0 : x_wide[W-1:0];

    // The arithmetic shift of the product is the floor of product / 2^32.
    assign cut_sum = {prod_reg[2*W-1], prod_reg[2*W-1:W]} + {cutoff_reg[W-1], cutoff_reg};

    always_comb
    begin
        if (cut_sum[W])
        begin
            idx = '0;
        end
        else if (cut_sum[W-1])
        begin
            idx = '1;
        end
        else
        begin
            idx = cut_sum[W-2:W-1-mopl_pkg::INDEX_W];
        end
    end

    assign d_next = {1'b0, y_prev_reg} - {1'b0, x_reg};

    assign num   = {2'b00, x_reg, {W{1'b0}}} + prod_reg;
    assign y_sat = (num[2*W+1:2*W] != 2'b00) ? '1 : num[2*W-1:W];
    assign res   = (y_sat == '1) ? {1'b0, {(W-1){1'b1}}}
                                 : y_sat - {1'b0, {(W-1){1'b1}}};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:  state_next = ST_LOOK;
            ST_LOOK: state_next = ST_FILT;
            ST_FILT: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            y_prev_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
                y_prev_reg    <= y_sat;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= x_in;
            cutoff_reg <= samples.cutoff_level;
            source_reg <= samples.mod_source;
            amount_reg <= samples.mod_amount;
        end
        if (state_reg inside {ST_MOD, ST_FILT})
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_LOOK)
        begin
            b_reg <= mopl_pkg::POLE_TABLE[idx];
            d_reg <= d_next;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            out_data_reg <= res;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.filtered_sample = out_data_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MOD)
        else $error("accepted beat did not start the modulation multiply");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result appeared outside the final step");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !results.ready) |=> state_reg == ST_FIN)
        else $error("final step left while the output register was full");

    a_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FIN) |=> $stable(y_prev_reg))
        else $error("filter state changed outside the final step");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_modulated_one_pole_lowpass_core.sv
// ============================================================================
// tb_modulated_one_pole_lowpass_core
// Drives sample beats into the modulated one-pole lowpass and checks every
// filtered sample against a cycle-free model of the filter. The model builds
// its own pole coefficient table and keeps its own copy of the filter state.
// It runs directed corner beats, a long random stream with bursts of idling
// on both channels, a long output hold-off and a final stretch at full rate.
// ============================================================================

module tb_modulated_one_pole_lowpass_core;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [mopl_pkg::SAMPLE_W-1:0] sample_t;

    localparam sample_t S_MAX = 32'sh7FFF_FFFF;
    localparam sample_t S_MIN = 32'sh8000_0000;

    localparam longint unsigned UNITY_Q32      = 64'h0000_0001_0000_0000;
    localparam longint unsigned PITCH_STEP_Q48 = 64'd301237215321;
    localparam longint          MID_OFFSET     = 64'sd2147483647;
    localparam longint          WORD_MAX       = 64'sd2147483647;
    localparam longint          WORD_MIN       = -64'sd2147483648;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_PAD   = 12;

    logic clk;
    logic rst_n;

    mopl_in_if  samples_if();
    mopl_out_if results_if();

    modulated_one_pole_lowpass_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    logic [mopl_pkg::SAMPLE_W-1:0] pole_coef [mopl_pkg::TABLE_ENTRIES];
    logic [mopl_pkg::SAMPLE_W-1:0] filter_state;
    sample_t                       pending_filtered [$];

    int  error_count;
    int  mismatch_count;
    int  cycle_count;
    bit  tx_gaps_on;
    bit  rx_stalls_on;
    int  rx_hold_request;

    // ------------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------------

    // exp(-w) for one note: Taylor series on w/16, then squared four times.
    function automatic logic [mopl_pkg::SAMPLE_W-1:0] note_pole(input int unsigned note);
        longint unsigned ratio;
        longint unsigned w;
        longint unsigned t;
        longint unsigned e;
        longint unsigned p;
        case (note % 12)
            0:       ratio = 64'd16777216;
            1:       ratio = 64'd17774841;
            2:       ratio = 64'd18831788;
            3:       ratio = 64'd19951585;
            4:       ratio = 64'd21137968;
            5:       ratio = 64'd22394897;
            6:       ratio = 64'd23726566;
            7:       ratio = 64'd25137421;
            8:       ratio = 64'd26632170;
            9:       ratio = 64'd28215802;
            10:      ratio = 64'd29893600;
            default: ratio = 64'd31671166;
        endcase
        w = (PITCH_STEP_Q48 * ratio) >> (40 - note / 12);
        t = w >> 4;
        e = UNITY_Q32 - t;
        p = (t * t) >> 32;
        e = e + p / 2;
        p = (p * t) >> 32;
        e = e - p / 6;
        p = (p * t) >> 32;
        e = e + p / 24;
        p = (p * t) >> 32;
        e = e - p / 120;
        p = (p * t) >> 32;
        e = e + p / 720;
        if (e > 64'h0000_0000_FFFF_FFFF)
        begin
            e = 64'h0000_0000_FFFF_FFFF;
        end
        for (int k = 0; k < 4; k++)
        begin
            e = (e * e) >> 32;
        end
        return e[mopl_pkg::SAMPLE_W-1:0];
    endfunction

    // Advances the filter state by one accepted beat and returns its output.
    function automatic sample_t predict_filtered(input sample_t smp, input sample_t cut,
                                                 input sample_t src, input sample_t amt);
        longint          prod;
        longint          cut_mod;
        longint          xs;
        longint          res;
        longint unsigned b;
        longint unsigned y;
        int unsigned     idx;
        prod    = longint'(amt) * longint'(src);
        // The arithmetic shift rounds the modulation term toward minus infinity.
        cut_mod = (prod >>> 32) + longint'(cut);
        if (cut_mod > WORD_MAX)
        begin
            cut_mod = WORD_MAX;
        end
        else if (cut_mod < WORD_MIN)
        begin
            cut_mod = WORD_MIN;
        end
        idx = (cut_mod < 0) ? 0 : int'(cut_mod >>> 24);
        if (idx > mopl_pkg::TABLE_ENTRIES - 1)
        begin
            idx = mopl_pkg::TABLE_ENTRIES - 1;
        end
        xs = longint'(smp) + MID_OFFSET;
        if (xs < 0)
        begin
            xs = 0;
        end
        b = {32'd0, pole_coef[idx]};
        y = ((UNITY_Q32 - b) * longint'(xs) + b * {32'd0, filter_state}) >> 32;
        if (y > 64'h0000_0000_FFFF_FFFF)
        begin
            y = 64'h0000_0000_FFFF_FFFF;
        end
        filter_state = y[mopl_pkg::SAMPLE_W-1:0];
        res = longint'(y) - MID_OFFSET;
        if (res > WORD_MAX)
        begin
            res = WORD_MAX;
        end
        return res[mopl_pkg::SAMPLE_W-1:0];
    endfunction

    // Random field value: mostly full range, some scaled down, some extremes.
    function automatic sample_t pick_field();
        sample_t v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = S_MIN;
                    1:       v = S_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3: v = sample_t'($signed($urandom)) >>> $urandom_range(1, 30);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_filtered.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------------

    initial
    begin
        int hold_left;
        int stall_left;
        hold_left        = 0;
        stall_left       = 0;
        results_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                results_if.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                results_if.ready = 1'b0;
                stall_left--;
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                results_if.ready = 1'b0;
                stall_left       = $urandom_range(1, 8) - 1;
            end
            else
            begin
                results_if.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_filtered.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Unexpected filtered beat %0d at cycle %0d",
                             results_if.filtered_sample, cycle_count);
                end
            end
            else
            begin
                want = pending_filtered.pop_front();
                if (results_if.filtered_sample !== want)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("filtered_sample mismatch at cycle %0d: expected %0d, got %0d",
                                 cycle_count, want, results_if.filtered_sample);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_sample(input sample_t smp, input sample_t cut,
                               input sample_t src, input sample_t amt);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            samples_if.valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
        end
        samples_if.valid        = 1'b1;
        samples_if.audio_sample = smp;
        samples_if.cutoff_level = cut;
        samples_if.mod_source   = src;
        samples_if.mod_amount   = amt;
        do
        begin
            @(posedge clk);
        end
        while (!samples_if.ready);
        pending_filtered.push_back(predict_filtered(smp, cut, src, amt));
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        samples_if.valid = 1'b0;
        while (pending_filtered.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_field_extremes();
        send_sample(S_MAX, '0, '0, '0);
        send_sample(S_MIN, '0, '0, '0);
        send_sample('0, S_MAX, '0, '0);
        send_sample('1, S_MIN, '0, '0);
        send_sample(S_MAX, '0, S_MAX, S_MAX);
        send_sample(S_MIN, '0, S_MIN, S_MIN);
        send_sample('0, '0, S_MIN, S_MAX);
        send_sample(32'sd1, 32'sh0100_0000, S_MAX, S_MIN);
    endtask

    task automatic test_special_cases();
        // Negative cutoff, directly and pulled below zero by the modulation.
        send_sample(32'sd12345, '1, '0, '0);
        send_sample('0, 32'sh0400_0000, S_MAX, S_MIN);
        // Modulated cutoff clamped at both ends of the word range.
        send_sample('0, S_MAX, S_MAX, S_MAX);
        send_sample('0, S_MIN, S_MIN, S_MAX);
        // Most negative sample with the fastest pole.
        send_sample(S_MIN, S_MAX, '0, '0);
        // A product of -1 must round down and drop the cutoff to the entry below.
        send_sample(32'sd100, 32'sh0100_0000, 32'sd1, '1);
        // Drive the output up against the positive limit with the fastest pole.
        repeat (8) send_sample(S_MAX, S_MAX, '0, '0);
        send_sample(S_MAX, '0, '0, '0);
        wait_results_drained();
    endtask

    task automatic test_random_stream(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       begin tx_gaps_on = 1'b1; rx_stalls_on = 1'b1; end
                    1:       begin tx_gaps_on = 1'b1; rx_stalls_on = 1'b0; end
                    2:       begin tx_gaps_on = 1'b0; rx_stalls_on = 1'b1; end
                    default: begin tx_gaps_on = 1'b0; rx_stalls_on = 1'b0; end
                endcase
            end
            send_sample(pick_field(), pick_field(), pick_field(), pick_field());
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // The result side holds off for a long time while beats keep coming,
    // then the sample side pauses until everything is out.
    task automatic test_backpressure();
        tx_gaps_on      = 1'b0;
        rx_hold_request = 150;
        repeat (40) send_sample(pick_field(), pick_field(), pick_field(), pick_field());
        wait_results_drained();
        tx_gaps_on = 1'b1;
        repeat (20) send_sample(pick_field(), pick_field(), pick_field(), pick_field());
    endtask

    task automatic test_full_rate(input int n_items);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (n_items) send_sample(pick_field(), pick_field(), pick_field(), pick_field());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n                   = 1'b0;
        samples_if.valid        = 1'b0;
        samples_if.audio_sample = '0;
        samples_if.cutoff_level = '0;
        samples_if.mod_source   = '0;
        samples_if.mod_amount   = '0;
        error_count             = 0;
        mismatch_count          = 0;
        tx_gaps_on              = 1'b1;
        rx_stalls_on            = 1'b1;
        rx_hold_request         = 0;
        filter_state            = '0;
        for (int n = 0; n < mopl_pkg::TABLE_ENTRIES; n++)
        begin
            pole_coef[n] = note_pole(n);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_special_cases();
        test_random_stream(1300);
        test_backpressure();
        test_full_rate(220);

        wait_results_drained();
        if (error_count == 0 && pending_filtered.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
